### rtl/bsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsc_pkg;

   typedef enum logic [1:0] {
      REG_TEMP,
      REG_PRESS_LOW,
      REG_PRESS_HIGH,
      REG_PRESS_NINE
   } reg_index_type;

   localparam int DIV_STEPS  = 64;
   localparam int PRE_STAGES = 10;
   localparam int POST_STAGES = 5;
   localparam int LATENCY    = PRE_STAGES + DIV_STEPS + 1 + POST_STAGES;

   localparam logic signed [32:0] TFINE_OFFSET = 33'sd128000;
   localparam logic [20:0]        PRESS_FULL   = 21'd1048576;
   localparam logic [63:0]        PRESS_SCALE  = 64'd3125;
   localparam logic signed [63:0] V1_BIAS      = 64'sh0000_8000_0000_0000;

   typedef struct packed {
      logic signed [31:0] tfine;
      logic               zero;
   } div_side_type;

   typedef struct packed {
      logic               valid;
      logic [63:0]        num;
      logic signed [30:0] den;
      div_side_type       side;
   } div_in_type;

   typedef struct packed {
      logic         valid;
      logic         neg;
      logic [63:0]  quo;
      div_side_type side;
   } div_out_type;

endpackage

`default_nettype wire

### rtl/bsc_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module bsc_divider
   import bsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_in_type  div_in,
   output div_out_type      div_out
);

   typedef struct packed {
      logic         valid;
      logic         neg;
      logic [31:0]  rem;
      logic [63:0]  num;
      logic [30:0]  md;
      div_side_type side;
   } stage_type;

   stage_type stage_ff [0:DIV_STEPS];
   stage_type stage0_in;

   function automatic stage_type div_step(input stage_type cur);
      stage_type   nxt;
      logic [31:0] shifted;
      logic        qbit;
      nxt     = cur;
      shifted = {cur.rem[30:0], cur.num[63]};
      qbit    = (shifted >= {1'b0, cur.md});
      nxt.rem = qbit ? shifted - {1'b0, cur.md} : shifted;
      nxt.num = {cur.num[62:0], qbit};
      return nxt;
   endfunction

   always_comb begin
      stage0_in.valid = div_in.valid;
      stage0_in.neg   = div_in.num[63] ^ div_in.den[30];
      stage0_in.rem   = '0;
      stage0_in.num   = div_in.num[63] ? 64'(-div_in.num) : div_in.num;
      stage0_in.md    = div_in.den[30] ? 31'(-div_in.den) : div_in.den;
      stage0_in.side  = div_in.side;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff[0].valid <= 1'b0;
      end else begin
         stage_ff[0] <= stage0_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k+1].valid <= 1'b0;
         end else begin
            stage_ff[k+1] <= div_step(stage_ff[k]);
         end
      end
   end

   assign div_out.valid = stage_ff[DIV_STEPS].valid;
   assign div_out.neg   = stage_ff[DIV_STEPS].neg;
   assign div_out.quo   = stage_ff[DIV_STEPS].num;
   assign div_out.side  = stage_ff[DIV_STEPS].side;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (stage_ff[DIV_STEPS].valid && stage_ff[DIV_STEPS].md != '0)
         |-> (stage_ff[DIV_STEPS].rem < {1'b0, stage_ff[DIV_STEPS].md}))
      else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### rtl/barometric_sensor_compensation_core.sv
// Channel    Handshake                       Payload
// request    start in, busy out              req_raw_temperature, req_raw_pressure
// result     rsp_valid strobe out            rsp_fine_temperature, rsp_pressure_q24_8,
//                                            rsp_divisor_zero
// csr        psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A request is taken in every cycle; busy stays low.
// Each result passes through the pre-divider stages, the 64-step divider pipeline and the post-divider stages.
// Synchronous reset clears all coefficients and every valid bit.
// Results are strobed for one cycle and the receiver cannot stall the pipeline.
`timescale 1ns / 1ps
`default_nettype none

module barometric_sensor_compensation_core
   import bsc_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [19:0]        req_raw_temperature,
   input  wire logic [19:0]        req_raw_pressure,
   output logic                    rsp_valid,
   output logic signed [31:0]      rsp_fine_temperature,
   output logic [31:0]             rsp_pressure_q24_8,
   output logic                    rsp_divisor_zero,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [4:0]         paddr,
   input  wire logic [63:0]        pwdata,
   output logic [63:0]             prdata,
   output logic                    pready
);

   logic [47:0] temp_coef_ff;
   logic [63:0] press_low_ff;
   logic [63:0] press_high_ff;
   logic [15:0] press_nine_ff;
   logic          csr_write;
   reg_index_type csr_index;

   assign pready    = 1'b1;
   assign busy      = 1'b0;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[4:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_coef_ff  <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_nine_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_TEMP:       temp_coef_ff  <= pwdata[47:0];
            REG_PRESS_LOW:  press_low_ff  <= pwdata;
            REG_PRESS_HIGH: press_high_ff <= pwdata;
            REG_PRESS_NINE: press_nine_ff <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_TEMP:       prdata = {16'd0, temp_coef_ff};
         REG_PRESS_LOW:  prdata = press_low_ff;
         REG_PRESS_HIGH: prdata = press_high_ff;
         REG_PRESS_NINE: prdata = {48'd0, press_nine_ff};
      endcase
   end

   logic [15:0]        t1, p1;
   logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
   logic signed [16:0] p1s;

   assign t1  = temp_coef_ff[15:0];
   assign t2  = temp_coef_ff[31:16];
   assign t3  = temp_coef_ff[47:32];
   assign p1  = press_low_ff[15:0];
   assign p2  = press_low_ff[31:16];
   assign p3  = press_low_ff[47:32];
   assign p4  = press_low_ff[63:48];
   assign p5  = press_high_ff[15:0];
   assign p6  = press_high_ff[31:16];
   assign p7  = press_high_ff[47:32];
   assign p8  = press_high_ff[63:48];
   assign p9  = press_nine_ff;
   assign p1s = {1'b0, p1};

   logic [PRE_STAGES:1]              pre_vld_ff;
   logic [PRE_STAGES+POST_STAGES:11] post_vld_ff;

   logic [19:0]        s1_adc_t_ff, s1_adc_p_ff;
   logic signed [33:0] s2_prod_a_ff, s2_bb_ff;
   logic [19:0]        s2_adc_p_ff;
   logic signed [22:0] s3_term1_ff;
   logic signed [37:0] s3_m_ff;
   logic [19:0]        s3_adc_p_ff;
   logic signed [31:0] s4_tfine_ff;
   logic [19:0]        s4_adc_p_ff;
   logic signed [31:0] s5_tfine_ff;
   logic signed [63:0] s5_sq_ff;
   logic signed [48:0] s5_pv5_ff, s5_pv2_ff;
   logic [19:0]        s5_adc_p_ff;
   logic signed [31:0] s6_tfine_ff;
   logic signed [63:0] s6_a6_ff, s6_a3_ff;
   logic signed [48:0] s6_pv5_ff, s6_pv2_ff;
   logic [19:0]        s6_adc_p_ff;
   logic signed [31:0] s7_tfine_ff;
   logic signed [63:0] s7_v2_ff, s7_u_ff;
   logic [19:0]        s7_adc_p_ff;
   logic signed [31:0] s8_tfine_ff;
   logic signed [63:0] s8_v2_ff, s8_x_ff;
   logic [19:0]        s8_adc_p_ff;
   logic signed [31:0] s9_tfine_ff;
   logic signed [30:0] s9_v1f_ff;
   logic [63:0]        s9_diff_ff;
   logic signed [31:0] s10_tfine_ff;
   logic signed [30:0] s10_v1f_ff;
   logic [63:0]        s10_num_ff;

   logic [17:0]        s1_a_in;
   logic [16:0]        s1_b_in;
   logic signed [17:0] s1_a;
   logic signed [16:0] s1_b;
   logic signed [21:0] s2_bbs;
   logic signed [32:0] s4_v1;
   logic signed [63:0] s8_xsh;
   logic [20:0]        s8_pfull;

   assign s1_a_in = 18'(s1_adc_t_ff[19:3]) - {1'b0, t1, 1'b0};
   assign s1_b_in = 17'(s1_adc_t_ff[19:4]) - {1'b0, t1};
   assign s1_a    = s1_a_in;
   assign s1_b    = s1_b_in;
   assign s2_bbs  = 22'(s2_bb_ff >>> 12);
   assign s4_v1   = s4_tfine_ff - TFINE_OFFSET;
   assign s8_xsh  = s8_x_ff >>> 33;
   assign s8_pfull = PRESS_FULL - {1'b0, s8_adc_p_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else begin
         pre_vld_ff <= {pre_vld_ff[PRE_STAGES-1:1], start && !busy};
      end
   end

   always_ff @(posedge clock) begin
      s1_adc_t_ff  <= req_raw_temperature;
      s1_adc_p_ff  <= req_raw_pressure;
      s2_prod_a_ff <= s1_a * t2;
      s2_bb_ff     <= s1_b * s1_b;
      s2_adc_p_ff  <= s1_adc_p_ff;
      s3_term1_ff  <= 23'(s2_prod_a_ff >>> 11);
      s3_m_ff      <= s2_bbs * t3;
      s3_adc_p_ff  <= s2_adc_p_ff;
      s4_tfine_ff  <= 32'(s3_term1_ff + (s3_m_ff >>> 14));
      s4_adc_p_ff  <= s3_adc_p_ff;
      s5_tfine_ff  <= s4_tfine_ff;
      s5_sq_ff     <= 64'(s4_v1 * s4_v1);
      s5_pv5_ff    <= s4_v1 * p5;
      s5_pv2_ff    <= s4_v1 * p2;
      s5_adc_p_ff  <= s4_adc_p_ff;
      s6_tfine_ff  <= s5_tfine_ff;
      s6_a6_ff     <= 64'(s5_sq_ff * p6);
      s6_a3_ff     <= 64'(s5_sq_ff * p3);
      s6_pv5_ff    <= s5_pv5_ff;
      s6_pv2_ff    <= s5_pv2_ff;
      s6_adc_p_ff  <= s5_adc_p_ff;
      s7_tfine_ff  <= s6_tfine_ff;
      s7_v2_ff     <= 64'(s6_a6_ff + (64'(s6_pv5_ff) <<< 17) + (64'(p4) <<< 35));
      s7_u_ff      <= 64'((s6_a3_ff >>> 8) + (64'(s6_pv2_ff) <<< 12) + V1_BIAS);
      s7_adc_p_ff  <= s6_adc_p_ff;
      s8_tfine_ff  <= s7_tfine_ff;
      s8_v2_ff     <= s7_v2_ff;
      s8_x_ff      <= 64'(s7_u_ff * p1s);
      s8_adc_p_ff  <= s7_adc_p_ff;
      s9_tfine_ff  <= s8_tfine_ff;
      s9_v1f_ff    <= s8_xsh[30:0];
      s9_diff_ff   <= {12'd0, s8_pfull, 31'd0} - s8_v2_ff;
      s10_tfine_ff <= s9_tfine_ff;
      s10_v1f_ff   <= s9_v1f_ff;
      s10_num_ff   <= s9_diff_ff * PRESS_SCALE;
   end

   div_in_type  div_in;
   div_out_type div_out;

   assign div_in.valid      = pre_vld_ff[PRE_STAGES];
   assign div_in.num        = s10_num_ff;
   assign div_in.den        = s10_v1f_ff;
   assign div_in.side.tfine = s10_tfine_ff;
   assign div_in.side.zero  = (s10_v1f_ff == '0);

   bsc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   div_side_type       s11_side_ff, s12_side_ff, s13_side_ff, s14_side_ff;
   logic signed [63:0] s11_q_ff, s12_q_ff, s12_wp8_ff;
   logic [63:0]        s12_ll_ff, s13_sq2_ff;
   logic [31:0]        s12_lh_ff;
   logic signed [63:0] s13_qw_ff, s14_qw_ff, s14_t_ff;
   logic signed [63:0] s11_s, s15_res;
   logic [31:0]        s11_sl, s11_sh;

   assign s11_s  = s11_q_ff >>> 13;
   assign s11_sl = s11_s[31:0];
   assign s11_sh = s11_s[63:32];
   assign s15_res = ((s14_qw_ff + (s14_t_ff >>> 25)) >>> 8) + (64'(p7) <<< 4);

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else begin
         post_vld_ff <= {post_vld_ff[PRE_STAGES+POST_STAGES-1:11], div_out.valid};
      end
   end

   always_ff @(posedge clock) begin
      s11_q_ff    <= div_out.neg ? 64'(-div_out.quo) : div_out.quo;
      s11_side_ff <= div_out.side;
      s12_q_ff    <= s11_q_ff;
      s12_ll_ff   <= s11_sl * s11_sl;
      s12_lh_ff   <= 32'(s11_sh * s11_sl);
      s12_wp8_ff  <= 64'(s11_q_ff * p8);
      s12_side_ff <= s11_side_ff;
      s13_sq2_ff  <= s12_ll_ff + {s12_lh_ff[30:0], 33'd0};
      s13_qw_ff   <= s12_q_ff + (s12_wp8_ff >>> 19);
      s13_side_ff <= s12_side_ff;
      s14_t_ff    <= 64'($signed(s13_sq2_ff) * p9);
      s14_qw_ff   <= s13_qw_ff;
      s14_side_ff <= s13_side_ff;
      rsp_fine_temperature <= s14_side_ff.tfine;
      rsp_divisor_zero     <= s14_side_ff.zero;
      rsp_pressure_q24_8   <= s14_side_ff.zero ? '0 : s15_res[31:0];
   end

   assign rsp_valid = post_vld_ff[PRE_STAGES+POST_STAGES];

   a_zero_forces_pressure: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divisor_zero) |-> (rsp_pressure_q24_8 == '0))
      else $error("zero divisor result carries nonzero pressure");

   a_result_has_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LATENCY))
      else $error("result without a request at the pipeline latency");

   a_temp_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && csr_index == REG_TEMP) |=> (temp_coef_ff == $past(pwdata[47:0])))
      else $error("temperature coefficient write lost");

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import bsc_pkg::*;

   typedef struct packed {
      logic [31:0] fine_temperature;
      logic [31:0] pressure_q24_8;
      logic        divisor_zero;
   } reading_type;

   typedef struct packed {
      logic [19:0] raw_temperature;
      logic [19:0] raw_pressure;
   } sample_type;

   localparam logic [63:0] FINE_OFFSET = 64'd128000;
   localparam logic [63:0] FULL_SCALE  = 64'd1048576;
   localparam logic [63:0] PA_SCALE    = 64'd3125;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [19:0] req_raw_temperature = '0;
   logic [19:0] req_raw_pressure = '0;
   logic        rsp_valid;
   logic signed [31:0] rsp_fine_temperature;
   logic [31:0] rsp_pressure_q24_8;
   logic        rsp_divisor_zero;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [4:0]  paddr = '0;
   logic [63:0] pwdata = '0;
   logic [63:0] prdata;
   logic        pready;

   logic [63:0] temp_coef;
   logic [63:0] press_low;
   logic [63:0] press_high;
   logic [63:0] press_nine;
   reading_type pending_readings[$];
   int          mismatches = 0;

   barometric_sensor_compensation_core dut (
      .clock, .reset, .start, .busy,
      .req_raw_temperature, .req_raw_pressure,
      .rsp_valid, .rsp_fine_temperature, .rsp_pressure_q24_8, .rsp_divisor_zero,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [63:0] asr(input logic [63:0] x, input int n);
      asr = $signed(x) >>> n;
   endfunction

   function automatic logic [63:0] sx16(input logic [15:0] v);
      sx16 = {{48{v[15]}}, v};
   endfunction

   function automatic reading_type compensate(input logic [19:0] rt, input logic [19:0] rp);
      logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic [63:0] a, b, term1, term2, tfine, v1, v2, p, num, mn, md, q, w1, w2;
      logic [31:0] tf;
      reading_type r;
      t1 = {48'd0, temp_coef[15:0]};
      t2 = sx16(temp_coef[31:16]);
      t3 = sx16(temp_coef[47:32]);
      p1 = {48'd0, press_low[15:0]};
      p2 = sx16(press_low[31:16]);
      p3 = sx16(press_low[47:32]);
      p4 = sx16(press_low[63:48]);
      p5 = sx16(press_high[15:0]);
      p6 = sx16(press_high[31:16]);
      p7 = sx16(press_high[47:32]);
      p8 = sx16(press_high[63:48]);
      p9 = sx16(press_nine[15:0]);
      a = ({44'd0, rt} >> 3) - (t1 << 1);
      term1 = asr(a * t2, 11);
      b = ({44'd0, rt} >> 4) - t1;
      term2 = asr(asr(b * b, 12) * t3, 14);
      tf = term1[31:0] + term2[31:0];
      tfine = {{32{tf[31]}}, tf};
      v1 = tfine - FINE_OFFSET;
      v2 = v1 * v1 * p6 + ((v1 * p5) << 17) + (p4 << 35);
      v1 = asr(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
      v1 = asr(((64'd1 << 47) + v1) * p1, 33);
      r.fine_temperature = tf;
      if (v1 == 64'd0) begin
         r.pressure_q24_8 = '0;
         r.divisor_zero = 1'b1;
      end else begin
         p = FULL_SCALE - {44'd0, rp};
         num = ((p << 31) - v2) * PA_SCALE;
         mn = num[63] ? -num : num;
         md = v1[63] ? -v1 : v1;
         q = mn / md;
         p = (num[63] != v1[63]) ? -q : q;
         w1 = asr(p9 * asr(p, 13) * asr(p, 13), 25);
         w2 = asr(p8 * p, 19);
         p = asr(p + w1 + w2, 8) + (p7 << 4);
         r.pressure_q24_8 = p[31:0];
         r.divisor_zero = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (!reset && rsp_valid) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected result %h %h %b", $time, rsp_fine_temperature,
                     rsp_pressure_q24_8, rsp_divisor_zero);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_fine_temperature !== want.fine_temperature) begin
               $display("%0t: fine_temperature expected %h actual %h", $time,
                        want.fine_temperature, rsp_fine_temperature);
               mismatches++;
            end
            if (rsp_pressure_q24_8 !== want.pressure_q24_8) begin
               $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                        want.pressure_q24_8, rsp_pressure_q24_8);
               mismatches++;
            end
            if (rsp_divisor_zero !== want.divisor_zero) begin
               $display("%0t: divisor_zero expected %b actual %b", $time,
                        want.divisor_zero, rsp_divisor_zero);
               mismatches++;
            end
         end
      end
   end

   task automatic write_register(input reg_index_type index, input logic [63:0] value);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= 5'(8 * int'(index));
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_TEMP:       temp_coef = value & 64'hFFFF_FFFF_FFFF;
         REG_PRESS_LOW:  press_low = value;
         REG_PRESS_HIGH: press_high = value;
         REG_PRESS_NINE: press_nine = value & 64'hFFFF;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [63:0] t, input logic [63:0] lo,
                            input logic [63:0] hi, input logic [63:0] nine);
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      write_register(REG_TEMP, t);
      write_register(REG_PRESS_LOW, lo);
      write_register(REG_PRESS_HIGH, hi);
      write_register(REG_PRESS_NINE, nine);
   endtask

   int burst_left = 0;

   task automatic send_request(input sample_type s, input logic typed,
                               input reading_type typed_reading);
      int gap;
      start <= 1'b1;
      req_raw_temperature <= s.raw_temperature;
      req_raw_pressure <= s.raw_pressure;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_readings.push_back(typed ? typed_reading
                                       : compensate(s.raw_temperature, s.raw_pressure));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic finish_phase();
      start <= 1'b0;
      @(posedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      case ($urandom_range(0, 3))
         0: begin
            s.raw_temperature = 20'($urandom);
            s.raw_pressure = 20'($urandom);
         end
         default: begin
            s.raw_temperature = 20'($urandom_range(400000, 640000));
            s.raw_pressure = 20'($urandom_range(250000, 560000));
         end
      endcase
      return s;
   endfunction

   typedef struct packed {
      sample_type  s;
      logic        typed;
      reading_type r;
   } stimulus_row_type;

   localparam reading_type NO_DIVISOR = '{32'd0, 32'd0, 1'b1};

   stimulus_row_type stimulus_table[] = '{
      '{'{20'd0, 20'd0}, 1'b1, NO_DIVISOR},
      '{'{20'hFFFFF, 20'hFFFFF}, 1'b1, NO_DIVISOR},
      '{'{20'd0, 20'hFFFFF}, 1'b1, NO_DIVISOR},
      '{'{20'hFFFFF, 20'd0}, 1'b1, NO_DIVISOR},
      '{'{20'h55555, 20'hAAAAA}, 1'b1, NO_DIVISOR},
      '{'{20'd519888, 20'd415148}, 1'b0, NO_DIVISOR},
      '{'{20'd0, 20'd0}, 1'b0, NO_DIVISOR},
      '{'{20'hFFFFF, 20'hFFFFF}, 1'b0, NO_DIVISOR},
      '{'{20'hAAAAA, 20'h55555}, 1'b0, NO_DIVISOR},
      '{'{20'd1, 20'd1}, 1'b0, NO_DIVISOR},
      '{'{20'h80000, 20'h80000}, 1'b0, NO_DIVISOR}
   };

   logic [63:0] phase_coefs[5][4] = '{
      '{64'h0000_FC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
        64'hC6F8_3C8C_FFF9_008C, 64'd6000},
      '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF},
      '{64'h0000_8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
        64'h8000_8000_8000_8000, 64'h8000},
      '{64'h0000_7FFF_7FFF_0000, 64'h7FFF_7FFF_7FFF_0001,
        64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF},
      '{64'h0000_FC18_6743_6B70, 64'h0B27_0BD0_D643_0000,
        64'hC6F8_3C8C_FFF9_008C, 64'd6000}
   };

   initial begin
      temp_coef = '0;
      press_low = '0;
      press_high = '0;
      press_nine = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stimulus_table[i])
         send_request(stimulus_table[i].s, stimulus_table[i].typed, stimulus_table[i].r);
      finish_phase();
      for (int ph = 0; ph < 7; ph++) begin
         if (ph < 5)
            configure(phase_coefs[ph][0], phase_coefs[ph][1], phase_coefs[ph][2],
                      phase_coefs[ph][3]);
         else
            configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom});
         if (ph == 0) begin
            send_request('{20'd0, 20'd0}, 1'b0, NO_DIVISOR);
            send_request('{20'hFFFFF, 20'hFFFFF}, 1'b0, NO_DIVISOR);
         end
         repeat (ph == 0 ? 110 : 45) send_request(random_sample(), 1'b0, NO_DIVISOR);
         finish_phase();
      end
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
